### rtl/lprp_pkg.sv
// shared constants and types for the lru page frame replacer
// no dependencies
package lprp_pkg;

  localparam int unsigned FRAMES = 16;
  localparam int unsigned PAGE_W = 16;
  localparam int unsigned IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned AGE_W  = IDX_W;
  localparam int unsigned CNT_W  = $clog2(FRAMES + 1);
  localparam int unsigned CFG_W  = 5;
  localparam int unsigned SLOT_W = 4;
  localparam int unsigned OCC_W  = 5;

  localparam logic [CFG_W-1:0] NUM_FRAMES_RST = CFG_W'(16);

  // lookup results rippling along the cell row
  typedef struct packed {
    logic              hit;
    logic [IDX_W-1:0]  hit_slot;
    logic [AGE_W-1:0]  hit_age;
    logic [IDX_W-1:0]  vic_slot;
    logic [PAGE_W-1:0] vic_page;
  } chain_t;

  // update command broadcast to every cell
  typedef struct packed {
    logic              en;
    logic              wr;
    logic [IDX_W-1:0]  slot;
    logic [CNT_W-1:0]  age_lim;
    logic [PAGE_W-1:0] page;
  } upd_t;

endpackage

### rtl/lprp_if.sv
// request, response and configuration channel interfaces
// depends on lprp_pkg
interface lprp_req_if import lprp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PAGE_W-1:0] page;
  logic              start_req;

  modport source (output valid, output page, output start_req, input ready);
  modport sink   (input valid, input page, input start_req, output ready);
endinterface

interface lprp_rsp_if import lprp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              hit;
  logic [SLOT_W-1:0] slot;
  logic              evicted_valid;
  logic [PAGE_W-1:0] evicted_page;
  logic [OCC_W-1:0]  occupied;

  modport source (output valid, output hit, output slot, output evicted_valid,
                  output evicted_page, output occupied, input ready);
  modport sink   (input valid, input hit, input slot, input evicted_valid,
                  input evicted_page, input occupied, output ready);
endinterface

interface lprp_cfg_if import lprp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] num_frames;

  modport source (output valid, output num_frames, input ready);
  modport sink   (input valid, input num_frames, output ready);
endinterface

### rtl/lru_page_frame_replacer.sv
// top level of the lru page frame replacer: control and the row of frame cells
// depends on lprp_pkg, lprp_if and lprp_cell
// a request is looked up in the cycle after acceptance; the frames are updated
//   in the update state once the response register is empty or being read, and
//   the response register is loaded with that update. a new request is accepted
//   only after the last one has been updated. reset empties all frames and sets
//   the frame count to 16; frame contents are not cleared.
module lru_page_frame_replacer import lprp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  lprp_req_if.sink   req_i,
  lprp_rsp_if.source rsp_o,
  lprp_cfg_if.sink   cfg_i
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOOK = 3'b010,
    ST_UPD  = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [CFG_W-1:0]  nf_q;
  logic [CNT_W-1:0]  used_q, used_d;
  logic [PAGE_W-1:0] page_q;
  chain_t            look_q;
  logic [CNT_W-1:0]  limit;
  logic [AGE_W-1:0]  vic_age;
  logic              req_fire;
  logic              upd_go;
  logic              fill;
  upd_t              upd;
  chain_t            chain [FRAMES+1];

  logic              rsp_valid_q;
  logic              rsp_hit_q;
  logic [SLOT_W-1:0] rsp_slot_q;
  logic              rsp_ev_q;
  logic [PAGE_W-1:0] rsp_evp_q;
  logic [OCC_W-1:0]  rsp_occ_q;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;

  always_comb begin
    if (nf_q == '0) begin
      limit = CNT_W'(1);
    end else if (CNT_W'(nf_q) > CNT_W'(FRAMES)) begin
      limit = CNT_W'(FRAMES);
    end else begin
      limit = CNT_W'(nf_q);
    end
  end

  assign vic_age = AGE_W'(used_q - CNT_W'(1));

  // cell row
  assign chain[0] = '0;
  for (genvar g = 0; g < FRAMES; g++) begin : g_cell
    lprp_cell u_cell (
      .clk_i    (clk_i),
      .slot_i   (IDX_W'(g)),
      .filled_i (CNT_W'(g) < used_q),
      .page_i   (page_q),
      .vic_age_i(vic_age),
      .chain_i  (chain[g]),
      .chain_o  (chain[g+1]),
      .upd_i    (upd)
    );
  end

  assign upd_go = (state_q == ST_UPD) && (!rsp_valid_q || rsp_o.ready);
  assign fill   = !look_q.hit && (used_q < limit);

  always_comb begin
    upd.en   = upd_go;
    upd.wr   = !look_q.hit;
    upd.page = page_q;
    if (look_q.hit) begin
      upd.slot    = look_q.hit_slot;
      upd.age_lim = CNT_W'(look_q.hit_age);
    end else if (fill) begin
      upd.slot    = IDX_W'(used_q);
      upd.age_lim = CNT_W'(FRAMES);
    end else begin
      upd.slot    = look_q.vic_slot;
      upd.age_lim = CNT_W'(vic_age);
    end
  end

  always_comb begin
    state_d = state_q;
    used_d  = used_q;
    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          state_d = ST_LOOK;
          if (req_i.start_req) begin
            used_d = '0;
          end
        end
      end
      ST_LOOK: state_d = ST_UPD;
      ST_UPD: begin
        if (upd_go) begin
          state_d = ST_IDLE;
          if (fill) begin
            used_d = used_q + CNT_W'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      nf_q        <= NUM_FRAMES_RST;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      if (cfg_i.valid && cfg_i.ready) begin
        nf_q <= cfg_i.num_frames;
      end
      if (upd_go) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      page_q <= req_i.page;
    end
    if (state_q == ST_LOOK) begin
      look_q <= chain[FRAMES];
    end
    if (upd_go) begin
      rsp_hit_q  <= look_q.hit;
      rsp_slot_q <= SLOT_W'(upd.slot);
      rsp_ev_q   <= !look_q.hit && !fill;
      rsp_evp_q  <= (!look_q.hit && !fill) ? look_q.vic_page : '0;
      rsp_occ_q  <= OCC_W'(used_d);
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.hit           = rsp_hit_q;
  assign rsp_o.slot          = rsp_slot_q;
  assign rsp_o.evicted_valid = rsp_ev_q;
  assign rsp_o.evicted_page  = rsp_evp_q;
  assign rsp_o.occupied      = rsp_occ_q;

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CNT_W'(FRAMES))
    else $error("occupancy exceeds frame count");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> !(rsp_o.hit && rsp_o.evicted_valid))
    else $error("hit reported together with an eviction");

  a_occ_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.occupied != '0))
    else $error("response with no frame occupied");

  a_upd_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_go |=> (used_q <= $past(used_q) + CNT_W'(1)))
    else $error("occupancy grew by more than one");

endmodule

### rtl/lprp_cell.sv
// one frame of the replacer: resident page and recency rank
// depends on lprp_pkg
module lprp_cell import lprp_pkg::*; (
  input  logic              clk_i,
  input  logic [IDX_W-1:0]  slot_i,
  input  logic              filled_i,
  input  logic [PAGE_W-1:0] page_i,
  input  logic [AGE_W-1:0]  vic_age_i,
  input  chain_t            chain_i,
  output chain_t            chain_o,
  input  upd_t              upd_i
);

  logic [PAGE_W-1:0] page_q;
  logic [AGE_W-1:0]  age_q;
  logic              hit_me;
  logic              vic_me;

  assign hit_me = filled_i && (page_q == page_i);
  // ranks are distinct, so the lru frame is the one ranked last
  assign vic_me = filled_i && (age_q == vic_age_i);

  always_comb begin
    chain_o = chain_i;
    if (!chain_i.hit && hit_me) begin
      chain_o.hit      = 1'b1;
      chain_o.hit_slot = slot_i;
      chain_o.hit_age  = age_q;
    end
    if (vic_me) begin
      chain_o.vic_slot = slot_i;
      chain_o.vic_page = page_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_i.en) begin
      if (upd_i.slot == slot_i) begin
        age_q <= '0;
        if (upd_i.wr) begin
          page_q <= upd_i.page;
        end
      end else if (filled_i && ({1'b0, age_q} < CNT_W'(upd_i.age_lim))) begin
        age_q <= age_q + AGE_W'(1);
      end
    end
  end

endmodule

### bench/lru_page_frame_replacer_tb.sv
`timescale 1ns / 100ps
// self-checking bench for lru_page_frame_replacer: page references, frame count writes
// depends on lprp_pkg, lprp_if and the rtl top level
module lru_page_frame_replacer_tb;
  import lprp_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned TAIL_CYCLES   = 20;
  localparam int unsigned CYCLE_LIMIT   = 500000;
  localparam int unsigned RANDOM_REFS   = 1800;
  localparam int unsigned MAX_PRINTS    = 60;

  typedef enum logic [1:0] {ITEM_REF, ITEM_CFG, ITEM_DRAIN} item_kind_e;
  typedef enum logic [1:0] {RDY_ALWAYS, RDY_COIN, RDY_PERIODIC, RDY_SPARSE} rdy_mode_e;

  typedef struct packed {
    item_kind_e        kind;
    logic [PAGE_W-1:0] page;
    logic              start;
    logic [CFG_W-1:0]  frames;
  } stim_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              evicted_valid;
    logic [PAGE_W-1:0] evicted_page;
    logic [OCC_W-1:0]  occupied;
  } frame_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  lprp_req_if req_if ();
  lprp_rsp_if rsp_if ();
  lprp_cfg_if cfg_if ();

  lru_page_frame_replacer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // driven copies of the channel inputs, known from time zero
  logic              drv_valid = 1'b0;
  logic [PAGE_W-1:0] drv_page  = '0;
  logic              drv_start = 1'b0;
  logic              cfg_valid = 1'b0;
  logic [CFG_W-1:0]  cfg_data  = NUM_FRAMES_RST;
  logic              rsp_rdy   = 1'b0;

  assign req_if.valid      = drv_valid;
  assign req_if.page       = drv_page;
  assign req_if.start_req  = drv_start;
  assign cfg_if.valid      = cfg_valid;
  assign cfg_if.num_frames = cfg_data;
  assign rsp_if.ready      = rsp_rdy;

  stim_t         ref_q[$];
  frame_result_t outcome_q[$];

  int unsigned req_sent  = 0;
  int unsigned rsp_seen  = 0;
  int unsigned err_cnt   = 0;
  int unsigned cycle_cnt = 0;

  // shadow of the frame table
  logic [PAGE_W-1:0] res_page [FRAMES];
  int unsigned       res_age  [FRAMES];
  int unsigned       res_used   = 0;
  logic [CFG_W-1:0]  frames_cfg = NUM_FRAMES_RST;

  task automatic report_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_PRINTS) $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  function automatic frame_result_t frame_access(input logic [PAGE_W-1:0] pg,
                                                 input logic clr);
    frame_result_t r;
    int unsigned   lim;
    int unsigned   sl;
    int unsigned   age_lim;
    bit            found;
    bit            fill;
    lim = (frames_cfg == 0) ? 1 : ((frames_cfg > FRAMES) ? FRAMES : frames_cfg);
    if (clr) res_used = 0;
    found = 1'b0;
    fill  = 1'b0;
    sl    = 0;
    r     = '0;
    for (int i = 0; i < res_used; i++) begin
      if (!found && res_page[i] == pg) begin
        found = 1'b1;
        sl    = i;
      end
    end
    if (found) begin
      age_lim = res_age[sl];
    end else if (res_used < lim) begin
      fill    = 1'b1;
      sl      = res_used;
      age_lim = FRAMES + 1;
    end else begin
      // victim carries the largest rank, even past a lowered frame count
      sl = 0;
      for (int i = 1; i < res_used; i++) begin
        if (res_age[i] > res_age[sl]) sl = i;
      end
      r.evicted_valid = 1'b1;
      r.evicted_page  = res_page[sl];
      age_lim         = res_age[sl];
    end
    for (int i = 0; i < res_used; i++) begin
      if (res_age[i] < age_lim) res_age[i]++;
    end
    res_page[sl] = pg;
    res_age[sl]  = 0;
    if (fill) res_used++;
    r.hit      = found;
    r.slot     = SLOT_W'(sl);
    r.occupied = OCC_W'(res_used);
    return r;
  endfunction

  task automatic queue_item(input stim_t s);
    ref_q.insert(ref_q.size(), s);
  endtask

  task automatic push_ref(input logic [PAGE_W-1:0] pg, input logic st);
    stim_t s;
    s = '{kind: ITEM_REF, page: pg, start: st, frames: '0};
    queue_item(s);
  endtask

  task automatic push_cfg(input logic [CFG_W-1:0] nf);
    stim_t s;
    s = '{kind: ITEM_CFG, page: '0, start: 1'b0, frames: nf};
    queue_item(s);
  endtask

  task automatic push_drain();
    stim_t s;
    s = '{kind: ITEM_DRAIN, page: '0, start: 1'b0, frames: '0};
    queue_item(s);
  endtask

  // request driver: bursts and gaps, frame count writes only once idle
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;
  int unsigned quiet      = 0;

  always @(posedge clk_i) begin : drive_proc
    bit hold;
    bit cfg_hold;
    bit n_valid;
    bit n_cfg;
    if (!rst_ni) begin
      drv_valid <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      hold     = drv_valid && !req_if.ready;
      cfg_hold = cfg_valid && !cfg_if.ready;
      if (cfg_valid && cfg_if.ready) frames_cfg = cfg_data;
      if (drv_valid && req_if.ready) begin
        outcome_q.insert(outcome_q.size(), frame_access(drv_page, drv_start));
        req_sent++;
      end
      if (req_sent == rsp_seen && !hold) quiet++;
      else quiet = 0;
      n_valid = hold;
      n_cfg   = cfg_hold;
      if (!hold && !cfg_hold) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (ref_q.size() > 0) begin
          case (ref_q[0].kind)
            ITEM_REF: begin
              drv_page  <= ref_q[0].page;
              drv_start <= ref_q[0].start;
              n_valid   = 1'b1;
              void'(ref_q.pop_front());
              burst_left--;
              if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 12)
                                                         : $urandom_range(0, 2);
              end
            end
            ITEM_CFG: begin
              if (quiet >= SETTLE_CYCLES) begin
                cfg_data <= ref_q[0].frames;
                n_cfg    = 1'b1;
                void'(ref_q.pop_front());
              end
            end
            default: begin
              if (req_sent == rsp_seen) void'(ref_q.pop_front());
            end
          endcase
        end
      end
      drv_valid <= n_valid;
      cfg_valid <= n_cfg;
    end
  end

  // response monitor with its own ready pattern
  rdy_mode_e   rdy_mode = RDY_ALWAYS;
  int unsigned seg_left = 0;
  int unsigned pat_cnt  = 0;

  always @(posedge clk_i) begin : check_proc
    frame_result_t want;
    bit            n_rdy;
    if (!rst_ni) begin
      rsp_rdy <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_rdy) begin
        rsp_seen <= rsp_seen + 1;
        if (outcome_q.size() == 0) begin
          report_mismatch("response with no request outstanding");
        end else begin
          want = outcome_q.pop_front();
          check_field("hit", 32'(rsp_if.hit), 32'(want.hit));
          check_field("slot", 32'(rsp_if.slot), 32'(want.slot));
          check_field("evicted_valid", 32'(rsp_if.evicted_valid),
                      32'(want.evicted_valid));
          check_field("evicted_page", 32'(rsp_if.evicted_page),
                      32'(want.evicted_page));
          check_field("occupied", 32'(rsp_if.occupied), 32'(want.occupied));
        end
      end
      if (seg_left == 0) begin
        rdy_mode = rdy_mode_e'($urandom_range(0, 3));
        seg_left = $urandom_range(10, 80);
      end else begin
        seg_left--;
      end
      pat_cnt++;
      case (rdy_mode)
        RDY_ALWAYS:   n_rdy = 1'b1;
        RDY_COIN:     n_rdy = 1'($urandom_range(0, 1));
        RDY_PERIODIC: n_rdy = (pat_cnt % 7) < 4;
        default:      n_rdy = ($urandom_range(0, 5) == 0);
      endcase
      rsp_rdy <= n_rdy;
    end
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin : watchdog_proc
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : run_proc
    logic [PAGE_W-1:0] pool [24];
    logic [CFG_W-1:0]  nf;
    int unsigned       eff;
    int unsigned       wsz;
    int unsigned       len;
    int unsigned       r;
    int unsigned       total;
    bit                fresh;

    // directed: four frames, fill, hit refresh, lru eviction, start over a resident page
    push_cfg(CFG_W'(4));
    push_ref(16'h0000, 1'b1);
    push_ref(16'hFFFF, 1'b0);
    push_ref(16'h0001, 1'b0);
    push_ref(16'h8000, 1'b0);
    push_ref(16'h0000, 1'b0);
    push_ref(16'h1234, 1'b0);
    push_ref(16'h8000, 1'b0);
    push_ref(16'hFFFF, 1'b0);
    push_ref(16'h8000, 1'b1);
    push_ref(16'h8000, 1'b0);
    // zero frame count behaves as one frame
    push_cfg(CFG_W'(0));
    push_ref(16'hAAAA, 1'b1);
    push_ref(16'h5555, 1'b0);
    push_ref(16'h5555, 1'b0);
    // count above the table size behaves as the full table
    push_cfg(CFG_W'(31));
    push_ref(16'h0F0F, 1'b0);
    push_ref(16'hF0F0, 1'b0);
    push_ref(16'h00FF, 1'b0);
    push_ref(16'hFF00, 1'b0);
    push_ref(16'h7FFF, 1'b0);
    // count lowered below occupancy: evict among all filled frames
    push_cfg(CFG_W'(2));
    push_ref(16'h3C3C, 1'b0);
    push_ref(16'h0F0F, 1'b0);
    push_ref(16'hC3C3, 1'b0);
    push_cfg(CFG_W'(16));
    push_ref(16'h3C3C, 1'b0);
    push_ref(16'h0001, 1'b0);
    push_drain();

    // random reference strings over a working set near the frame count
    total = 0;
    while (total < RANDOM_REFS) begin
      case ($urandom_range(0, 7))
        0:       nf = CFG_W'(1);
        1:       nf = CFG_W'(16);
        2:       nf = CFG_W'(0);
        3:       nf = CFG_W'(31);
        4:       nf = CFG_W'($urandom_range(17, 31));
        default: nf = CFG_W'($urandom_range(1, 16));
      endcase
      push_cfg(nf);
      eff = (nf == 0) ? 1 : ((nf > FRAMES) ? FRAMES : nf);
      wsz = eff + $urandom_range(0, 4);
      wsz = (wsz > 2) ? wsz - 2 : 1;
      for (int i = 0; i < 24; i++) pool[i] = PAGE_W'($urandom_range(0, 65535));
      len   = $urandom_range(40, 120);
      fresh = ($urandom_range(0, 3) != 0);
      for (int k = 0; k < len; k++) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          push_ref(PAGE_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
        end else begin
          // drift the working set now and then
          if (r < 13) pool[$urandom_range(0, wsz - 1)] = PAGE_W'($urandom_range(0, 65535));
          push_ref(pool[$urandom_range(0, wsz - 1)],
                   (k == 0 && fresh) || ($urandom_range(0, 99) == 0));
        end
        total++;
      end
      if ($urandom_range(0, 3) == 0) push_drain();
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (ref_q.size() != 0 || drv_valid || cfg_valid || outcome_q.size() != 0);
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (outcome_q.size() != 0)
      report_mismatch($sformatf("%0d responses never arrived", outcome_q.size()));
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
